// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the Modbus frame builder.
// Each macro checks a property on the rising edge of clk, disabled while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property with the reset disable.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication from a condition to a property in the same cycle.
`define ASSERT_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Implication from a condition to a property in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== sv/mrwfb_pkg.sv =====
// Shared constants and types of the Modbus RTU write frame builder.
// Depends on nothing; used by the sequencer, the CRC unit and the top level.
package mrwfb_pkg;

	// Largest register count in a multiple write; larger requests saturate.
	localparam logic [4:0] MAX_REGS = 5'd27;

	// Modbus function codes.
	localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
	localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

	// CRC-16 (Modbus) constants.
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Frame byte positions of the fixed header.
	localparam logic [5:0] POS_SLAVE   = 6'd0;
	localparam logic [5:0] POS_FUNC    = 6'd1;
	localparam logic [5:0] POS_ADDR_HI = 6'd2;
	localparam logic [5:0] POS_ADDR_LO = 6'd3;
	localparam logic [5:0] POS_WORD_HI = 6'd4;
	localparam logic [5:0] POS_WORD_LO = 6'd5;
	localparam logic [5:0] POS_BCOUNT  = 6'd6;

	// Data bytes before the CRC: single write and fixed part of a multiple write.
	localparam logic [5:0] LEN_SINGLE     = 6'd6;
	localparam logic [5:0] LEN_MULTI_HEAD = 6'd7;

	// Control from the sequencer to the CRC unit.
	typedef struct packed {
		logic       init;
		logic       update;
		logic [7:0] data;
	} crc_ctrl_t;

endpackage

// ===== sv/modbus_rtu_write_frame_builder.sv =====
// Modbus RTU write request frame builder: slave register, sequencer, CRC-16 unit.
// A request is captured into the sequencer registers; each frame byte then goes to the output register.
// One byte per cycle while the output is not stalled; a frame of n bytes (8, or 9 + 2*count) holds
// the request port busy until its closing CRC byte is loaded into the output register.
// Reset (arst_n, asynchronous, active low): slave address 1, sequencer idle, no output.
`include "assert_macros.svh"

module modbus_rtu_write_frame_builder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  slave_address,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [15:0] reg_address,
	input  logic [15:0] reg_value,
	input  logic [4:0]  reg_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  tx_byte,
	output logic        last_byte
);

	logic [7:0]           slave_q;
	logic [15:0]          crc_value;
	mrwfb_pkg::crc_ctrl_t crc_ctrl;

	// Slave address register; a write is taken in any cycle and is meant to come between frames.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			slave_q <= slave_address;
		end
	end

	// Byte sequencer and output register.
	mrwfb_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.reg_address (reg_address),
		.reg_value   (reg_value),
		.reg_count   (reg_count),
		.slave_addr  (slave_q),
		.crc_value   (crc_value),
		.crc_ctrl    (crc_ctrl),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.tx_byte     (tx_byte),
		.last_byte   (last_byte)
	);

	// Shared checksum unit.
	mrwfb_crc16 u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.crc    (crc_value)
	);

	// An accepted request keeps the block busy in the following cycle.
	`ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall, "request accepted but block not busy")
	// Leaving busy means the closing CRC byte has just been loaded.
	`ASSERT_IMPL(a_end_on_last, $fell(in_stall), out_valid && last_byte, "frame ended without last byte")
	// While idle, only the closing byte of a frame may still wait at the output.
	`ASSERT_IMPL(a_idle_only_last, out_valid && !in_stall, last_byte, "idle with a non-final byte pending")

endmodule

// ===== sv/mrwfb_crc16.sv =====
// Shared CRC-16 unit: folds one frame byte per cycle, when update is set, into the running checksum.
// Depends on mrwfb_pkg for the polynomial, initial value and control struct.
module mrwfb_crc16 (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mrwfb_pkg::crc_ctrl_t  ctrl,
	output logic [15:0]           crc
);

	logic [15:0] crc_q;

	// One byte through the reflected polynomial, eight shift steps.
	function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ mrwfb_pkg::CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// Running checksum register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= mrwfb_pkg::CRC_INIT;
		end else if (ctrl.init) begin
			crc_q <= mrwfb_pkg::CRC_INIT;
		end else if (ctrl.update) begin
			crc_q <= crc_byte(crc_q, ctrl.data);
		end
	end

	assign crc = crc_q;

endmodule

// ===== sv/mrwfb_seq.sv =====
// Frame sequencer: holds one request, walks the frame byte by byte and drives
// the output register and the CRC unit. Depends on mrwfb_pkg.
module mrwfb_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	input  logic [15:0]           reg_address,
	input  logic [15:0]           reg_value,
	input  logic [4:0]            reg_count,
	input  logic [7:0]            slave_addr,
	input  logic [15:0]           crc_value,
	output mrwfb_pkg::crc_ctrl_t  crc_ctrl,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            tx_byte,
	output logic                  last_byte
);

	logic        busy_q;
	logic        type_q;
	logic [15:0] addr_q;
	logic [15:0] val_q;
	logic [4:0]  cnt_q;
	logic [5:0]  idx_q;
	logic        out_valid_q;
	logic [7:0]  tx_q;
	logic        last_q;

	logic        accept;
	logic        advance;
	logic [5:0]  data_len;
	logic        is_crc_lo;
	logic        is_crc_hi;
	logic [7:0]  data_byte;
	logic [7:0]  next_byte;

	assign accept  = in_valid && !busy_q;
	assign advance = busy_q && (!out_valid_q || !out_stall);

	// Number of bytes covered by the checksum.
	assign data_len  = type_q ? (mrwfb_pkg::LEN_MULTI_HEAD + {cnt_q, 1'b0})
	                          : mrwfb_pkg::LEN_SINGLE;
	assign is_crc_lo = (idx_q == data_len);
	assign is_crc_hi = (idx_q == data_len + 6'd1);

	// Frame byte at the current position.
	always_comb begin
		if (idx_q == mrwfb_pkg::POS_SLAVE) begin
			data_byte = slave_addr;
		end else if (idx_q == mrwfb_pkg::POS_FUNC) begin
			data_byte = type_q ? mrwfb_pkg::FC_WRITE_MULTI : mrwfb_pkg::FC_WRITE_SINGLE;
		end else if (idx_q == mrwfb_pkg::POS_ADDR_HI) begin
			data_byte = addr_q[15:8];
		end else if (idx_q == mrwfb_pkg::POS_ADDR_LO) begin
			data_byte = addr_q[7:0];
		end else if (idx_q == mrwfb_pkg::POS_WORD_HI) begin
			data_byte = type_q ? 8'h00 : val_q[15:8];
		end else if (idx_q == mrwfb_pkg::POS_WORD_LO) begin
			data_byte = type_q ? {3'b000, cnt_q} : val_q[7:0];
		end else if (idx_q == mrwfb_pkg::POS_BCOUNT) begin
			data_byte = {2'b00, cnt_q, 1'b0};
		end else begin
			// Repeated value: high byte at odd positions, low byte at even ones.
			data_byte = idx_q[0] ? val_q[15:8] : val_q[7:0];
		end
	end

	// The two trailing checksum bytes, low byte first.
	always_comb begin
		if (is_crc_lo) begin
			next_byte = crc_value[7:0];
		end else if (is_crc_hi) begin
			next_byte = crc_value[15:8];
		end else begin
			next_byte = data_byte;
		end
	end

	// Checksum control: restart on a new request, fold in each data byte sent.
	always_comb begin
		crc_ctrl.init   = accept;
		crc_ctrl.update = advance && !is_crc_lo && !is_crc_hi;
		crc_ctrl.data   = data_byte;
	end

	// Request capture; the count saturates on the way in.
	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= req_type;
			addr_q <= reg_address;
			val_q  <= reg_value;
			cnt_q  <= (reg_count > mrwfb_pkg::MAX_REGS) ? mrwfb_pkg::MAX_REGS : reg_count;
		end
	end

	// Sequencer control: busy flag and byte position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 6'd0;
		end else if (accept) begin
			busy_q <= 1'b1;
			idx_q  <= 6'd0;
		end else if (advance) begin
			idx_q <= idx_q + 6'd1;
			if (is_crc_hi) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			tx_q   <= next_byte;
			last_q <= is_crc_hi;
		end
	end

	assign in_stall  = busy_q;
	assign out_valid = out_valid_q;
	assign tx_byte   = tx_q;
	assign last_byte = last_q;

endmodule
